### sv/dfq_pkg.sv
// Shared constants, codes and types of the deduplicating queue.
`timescale 1ns / 1ps

package dfq_pkg;

  // Queue geometry
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned OCC_W   = 7;
  localparam int unsigned STAT_W  = 2;

  // Match reduction: hits are ORed in groups, then across groups
  localparam int unsigned GROUP   = 8;
  localparam int unsigned NGRP    = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_DUP   = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  // Per-cycle control of one storage cell
  typedef struct packed {
    logic load;   // take the incoming value
    logic shift;  // take the neighbour's word
    logic held;   // cell lies inside the occupied region
  } cell_ctl_t;

endpackage

### sv/dfq_cmd_if.sv
// Command channel: action and value with a valid/ready handshake.
`timescale 1ns / 1ps

interface dfq_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [dfq_pkg::VAL_W-1:0]    value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

### sv/dfq_rsp_if.sv
// Response channel: status, removed value and occupancy with a valid/ready handshake.
`timescale 1ns / 1ps

interface dfq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [dfq_pkg::STAT_W-1:0]          status;
  logic signed [dfq_pkg::VAL_W-1:0]    removed;
  logic [dfq_pkg::OCC_W-1:0]           occupancy;

  modport source (output valid, output status, output removed, output occupancy, input ready);
  modport sink   (input valid, input status, input removed, input occupancy, output ready);
endinterface

### sv/dedup_fifo_queue_core.sv
// Top level of the deduplicating queue: command sequencer, cell row and response register.
`timescale 1ns / 1ps

// A first-in first-out queue of up to dfq_pkg::DEPTH signed 32-bit values that refuses an
// enqueue when full or when the value is already held, and a dequeue when empty. Every
// command gives one response with a status, the removed value (zero unless a dequeue
// succeeded) and the occupancy afterwards. A command passes through four steps: accept, compare in
// every cell at once, OR the registered hits in groups of dfq_pkg::GROUP, then decide and
// update the cell row, which shifts all cells together on a dequeue. The next command is
// accepted in the cycle after the update. The response sits in an output register, so a
// new command is taken while it waits; the decide step holds only if the previous response
// is still untaken.
module dedup_fifo_queue_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  dfq_cmd_if.sink    cmd_i,
  dfq_rsp_if.source  rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_DEC
  } state_e;

  state_e                           state_q;
  logic                             action_q;
  logic signed [dfq_pkg::VAL_W-1:0] value_q;
  logic [dfq_pkg::CNT_W-1:0]        count_q;
  logic [dfq_pkg::CNT_W-1:0]        count_d;

  logic                             rsp_valid_q;
  logic [dfq_pkg::STAT_W-1:0]       status_q;
  logic signed [dfq_pkg::VAL_W-1:0] removed_q;
  logic [dfq_pkg::OCC_W-1:0]        occ_q;

  logic                             dec_fire;
  logic                             dup;
  logic signed [dfq_pkg::VAL_W-1:0] head;
  logic                             load;
  logic                             shift;
  dfq_pkg::status_e                 status_d;
  logic signed [dfq_pkg::VAL_W-1:0] removed_d;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign dec_fire    = (state_q == S_DEC) && (!rsp_valid_q || rsp_o.ready);

  // Decide the outcome of the pending command
  always_comb begin
    status_d  = dfq_pkg::STAT_DONE;
    removed_d = '0;
    load      = 1'b0;
    shift     = 1'b0;
    count_d   = count_q;
    if (action_q == dfq_pkg::ACT_ENQ) begin
      if (count_q == dfq_pkg::CNT_W'(dfq_pkg::DEPTH)) begin
        status_d = dfq_pkg::STAT_FULL;
      end else if (dup) begin
        status_d = dfq_pkg::STAT_DUP;
      end else begin
        load    = dec_fire;
        count_d = count_q + dfq_pkg::CNT_W'(1);
      end
    end else begin
      if (count_q == '0) begin
        status_d = dfq_pkg::STAT_EMPTY;
      end else begin
        shift     = dec_fire;
        removed_d = head;
        count_d   = count_q - dfq_pkg::CNT_W'(1);
      end
    end
  end

  dfq_chain u_chain (
    .clk_i   (clk_i),
    .count_i (count_q),
    .load_i  (load),
    .shift_i (shift),
    .value_i (value_q),
    .head_o  (head),
    .dup_o   (dup)
  );

  // Sequence the command and hold the response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      // Raise the response on a decided command, drop it once taken
      if (dec_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_RED;
        end
        S_RED: begin
          state_q <= S_DEC;
        end
        S_DEC: begin
          if (dec_fire) begin
            state_q <= S_IDLE;
            count_q <= count_d;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the command and response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      action_q <= cmd_i.action;
      value_q  <= cmd_i.value;
    end
    if (dec_fire) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      occ_q     <= dfq_pkg::OCC_W'(count_d);
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.removed   = removed_q;
  assign rsp_o.occupancy = occ_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dfq_pkg::CNT_W'(dfq_pkg::DEPTH))
    else $error("occupancy above queue depth");

  a_count_only_on_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(dec_fire))
    else $error("occupancy changed outside the decide step");

  a_rsp_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_fire |=> rsp_o.valid)
    else $error("no response after a decided command");

  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == dfq_pkg::STAT_EMPTY)) |->
      ((rsp_o.removed == '0) && (rsp_o.occupancy == '0)))
    else $error("empty status with a removed value or nonzero occupancy");

  a_full_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_fire && (status_d == dfq_pkg::STAT_FULL)) |->
      (count_q == dfq_pkg::CNT_W'(dfq_pkg::DEPTH)))
    else $error("full status below queue depth");
`endif

endmodule

### sv/dfq_cell.sv
// One queue cell: holds a word, compares it with the probe and hands it to its neighbour.
`timescale 1ns / 1ps

module dfq_cell (
  input  logic                             clk_i,
  input  dfq_pkg::cell_ctl_t               ctl_i,
  input  logic signed [dfq_pkg::VAL_W-1:0] value_i,
  input  logic signed [dfq_pkg::VAL_W-1:0] next_i,
  output logic signed [dfq_pkg::VAL_W-1:0] data_o,
  output logic                             hit_o
);

  logic signed [dfq_pkg::VAL_W-1:0] data_q;
  logic                             hit_q;

  // Advance on dequeue, otherwise load the appended value
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      data_q <= next_i;
    end else if (ctl_i.load) begin
      data_q <= value_i;
    end
  end

  // Register the match of a held word against the probe
  always_ff @(posedge clk_i) begin
    hit_q <= ctl_i.held && (data_q == value_i);
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

### sv/dfq_chain.sv
// Row of queue cells with the grouped match reduction.
`timescale 1ns / 1ps

module dfq_chain (
  input  logic                             clk_i,
  input  logic [dfq_pkg::CNT_W-1:0]        count_i,
  input  logic                             load_i,
  input  logic                             shift_i,
  input  logic signed [dfq_pkg::VAL_W-1:0] value_i,
  output logic signed [dfq_pkg::VAL_W-1:0] head_o,
  output logic                             dup_o
);

  logic signed [dfq_pkg::VAL_W-1:0]          data_w [dfq_pkg::DEPTH];
  logic [dfq_pkg::NGRP*dfq_pkg::GROUP-1:0]   hit_w;
  logic [dfq_pkg::NGRP-1:0]                  grp_q;

  // Build the row; the last cell takes its own word on a shift
  for (genvar i = 0; i < dfq_pkg::DEPTH; i++) begin : g_cell
    dfq_pkg::cell_ctl_t               ctl;
    logic signed [dfq_pkg::VAL_W-1:0] nxt;

    assign ctl.held  = (count_i > dfq_pkg::CNT_W'(i));
    assign ctl.load  = load_i && (count_i == dfq_pkg::CNT_W'(i));
    assign ctl.shift = shift_i;

    if (i == dfq_pkg::DEPTH - 1) begin : g_last
      assign nxt = data_w[i];
    end else begin : g_mid
      assign nxt = data_w[i+1];
    end

    dfq_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .value_i (value_i),
      .next_i  (nxt),
      .data_o  (data_w[i]),
      .hit_o   (hit_w[i])
    );
  end

  // Pad unused group slots
  if (dfq_pkg::NGRP * dfq_pkg::GROUP > dfq_pkg::DEPTH) begin : g_pad
    assign hit_w[dfq_pkg::NGRP*dfq_pkg::GROUP-1:dfq_pkg::DEPTH] = '0;
  end

  // Reduce hits per group into registers
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < dfq_pkg::NGRP; g++) begin
      grp_q[g] <= |hit_w[g*dfq_pkg::GROUP +: dfq_pkg::GROUP];
    end
  end

  assign dup_o  = |grp_q;
  assign head_o = data_w[0];

endmodule
